// ----- sv/tmm_pkg.sv -----
// shared types and constants for the tiled matrix multiply block
package tmm_pkg;

    // widest tile edge, one accumulating cell per tile column
    localparam int CELLS = 8;
    localparam int CIW = 3;
    localparam int DATA_W = 32;

    // length of the drain after the last issued term: its product is summed by the cell for its
    // tile column and leaves the chain before the drain ends
    localparam logic [3:0] DRAIN_LEN = 4'd11;

    // configuration register reset and request codes
    localparam logic [1:0] TILE_LOG2_RESET = 2'd2;
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // one product travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic [CIW-1:0]    dest;
        logic [DATA_W-1:0] prod;
    } t_link;

endpackage

// ----- sv/tiled_integer_matrix_multiply.sv -----
// top level: matrix stores, tile sequencer, multiplier and chain of accumulating cells
// the sequencer issues one dot-product term per cycle into the chain, one tile row at a time
// the memories have one read port each, which sets the rate of one term per cycle
// loads are written into the stores as they are accepted; one item is worked on at a time
// reset clears control state and sets tile_size_log2 to 2; matrix contents stay unknown until loaded
module tiled_integer_matrix_multiply #(
    parameter int MATRIX_DIM = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic signed [31:0] i_element_value,
    input  logic [7:0]         i_tile_index,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_out_row,
    output logic [3:0]         o_out_col,
    output logic signed [31:0] o_product_value,
    output logic               o_last_of_tile
);

    localparam int IW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);
    localparam int PW = $clog2(MATRIX_DIM + 1);
    localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;
    localparam logic [IW-1:0] K_LAST = IW'(MATRIX_DIM - 1);

    tmm_pkg::t_state r_state, n_state;

    logic [1:0]    r_tile_log2;
    logic [7:0]    r_rem, n_rem;
    logic [7:0]    r_tx, n_tx;
    logic [IW-1:0] r_i_base, n_i_base;
    logic [IW-1:0] r_j_base, n_j_base;
    logic [2:0]    r_r, n_r;
    logic [2:0]    r_c, n_c;
    logic [IW-1:0] r_k, n_k;
    logic [3:0]    r_drain, n_drain;
    logic          r_clear, n_clear;

    logic [31:0]   r_mem_a [DEPTH];
    logic [31:0]   r_mem_b [DEPTH];
    logic [31:0]   r_a_q, r_b_q;

    logic          r_p1_valid;
    logic [2:0]    r_p1_dest;
    tmm_pkg::t_link r_p2;

    logic          r_out_valid;
    logic [3:0]    r_out_row;
    logic [3:0]    r_out_col;
    logic [31:0]   r_out_prod;
    logic          r_out_last;

    logic          w_in_acc;
    logic          w_cfg_wr;
    logic [PW-1:0] w_per_side;
    logic [2:0]    w_edge_m1;
    logic          w_rem_ge;
    logic          w_tx_ok;
    logic          w_out_free;
    logic          w_ld_ok;
    logic [AW-1:0] w_ld_addr;
    logic [AW-1:0] w_a_addr;
    logic [AW-1:0] w_b_addr;
    logic [IW-1:0] w_i;
    logic [IW-1:0] w_j;

    tmm_pkg::t_link w_link [tmm_pkg::CELLS+1];
    logic [31:0]    w_acc [tmm_pkg::CELLS];

    // handshakes and tile geometry
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != tmm_pkg::ST_IDLE);
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign w_per_side = PW'(32'(MATRIX_DIM) >> r_tile_log2);
    assign w_edge_m1 = 3'((4'd1 << r_tile_log2) - 4'd1);
    assign w_rem_ge = 32'(r_rem) >= 32'(w_per_side);
    assign w_tx_ok = 32'(r_tx) < 32'(w_per_side);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, r_tile_log2} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_log2 <= tmm_pkg::TILE_LOG2_RESET;
        end else if (w_cfg_wr) begin
            r_tile_log2 <= pwdata[1:0];
        end
    end

    // addresses for loads and for the term being issued
    assign w_ld_ok = (32'(i_row_index) < 32'(MATRIX_DIM)) && (32'(i_col_index) < 32'(MATRIX_DIM));
    assign w_ld_addr = AW'(32'(i_row_index) * 32'(MATRIX_DIM) + 32'(i_col_index));
    assign w_i = r_i_base + IW'(r_r);
    assign w_j = r_j_base + IW'(r_c);
    assign w_a_addr = AW'(32'(w_i) * 32'(MATRIX_DIM) + 32'(r_k));
    assign w_b_addr = AW'(32'(r_k) * 32'(MATRIX_DIM) + 32'(w_j));

    // matrix stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_ld_ok && i_req_type == tmm_pkg::REQ_LOAD_A) begin
            r_mem_a[w_ld_addr] <= i_element_value;
        end
        r_a_q <= r_mem_a[w_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_ld_ok && i_req_type == tmm_pkg::REQ_LOAD_B) begin
            r_mem_b[w_ld_addr] <= i_element_value;
        end
        r_b_q <= r_mem_b[w_b_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmm_pkg::ST_IDLE: begin
                if (w_in_acc && i_req_type == tmm_pkg::REQ_COMPUTE && w_per_side != '0) begin
                    n_state = tmm_pkg::ST_SETUP;
                end
            end
            tmm_pkg::ST_SETUP: begin
                if (!w_rem_ge) begin
                    n_state = w_tx_ok ? tmm_pkg::ST_ISSUE : tmm_pkg::ST_IDLE;
                end
            end
            tmm_pkg::ST_ISSUE: begin
                if (r_c == w_edge_m1 && r_k == K_LAST) begin
                    n_state = tmm_pkg::ST_DRAIN;
                end
            end
            tmm_pkg::ST_DRAIN: begin
                if (r_drain == tmm_pkg::DRAIN_LEN - 4'd1) begin
                    n_state = tmm_pkg::ST_EMIT;
                end
            end
            tmm_pkg::ST_EMIT: begin
                if (w_out_free && r_c == w_edge_m1) begin
                    n_state = (r_r == w_edge_m1) ? tmm_pkg::ST_IDLE : tmm_pkg::ST_ISSUE;
                end
            end
            default: n_state = tmm_pkg::ST_IDLE;
        endcase
    end

    // sequencer counters
    always_comb begin
        n_rem = r_rem;
        n_tx = r_tx;
        n_i_base = r_i_base;
        n_j_base = r_j_base;
        n_r = r_r;
        n_c = r_c;
        n_k = r_k;
        n_drain = r_drain;
        n_clear = 1'b0;
        case (r_state)
            tmm_pkg::ST_IDLE: begin
                n_rem = i_tile_index;
                n_tx = '0;
            end
            tmm_pkg::ST_SETUP: begin
                // tile row by repeated subtraction, remainder is the tile column
                if (w_rem_ge) begin
                    n_rem = 8'(32'(r_rem) - 32'(w_per_side));
                    n_tx = r_tx + 8'd1;
                end else begin
                    n_i_base = IW'(32'(r_tx) << r_tile_log2);
                    n_j_base = IW'(32'(r_rem) << r_tile_log2);
                    n_r = '0;
                    n_c = '0;
                    n_k = '0;
                    n_clear = 1'b1;
                end
            end
            tmm_pkg::ST_ISSUE: begin
                // column-minor, term-major issue order
                if (r_c == w_edge_m1) begin
                    n_c = '0;
                    n_k = r_k + IW'(1);
                end else begin
                    n_c = r_c + 3'd1;
                end
                n_drain = '0;
            end
            tmm_pkg::ST_DRAIN: begin
                n_drain = r_drain + 4'd1;
            end
            tmm_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    if (r_c == w_edge_m1) begin
                        n_c = '0;
                        n_k = '0;
                        n_r = r_r + 3'd1;
                        n_clear = 1'b1;
                    end else begin
                        n_c = r_c + 3'd1;
                    end
                end
            end
            default: begin
                n_clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmm_pkg::ST_IDLE;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clear <= n_clear;
        end
        r_rem <= n_rem;
        r_tx <= n_tx;
        r_i_base <= n_i_base;
        r_j_base <= n_j_base;
        r_r <= n_r;
        r_c <= n_c;
        r_k <= n_k;
        r_drain <= n_drain;
    end

    // read tag and product stages feeding the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2.valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == tmm_pkg::ST_ISSUE);
            r_p2.valid <= r_p1_valid;
        end
        r_p1_dest <= r_c;
        r_p2.dest <= r_p1_dest;
        r_p2.prod <= 32'(r_a_q * r_b_q);
    end

    // chain of accumulating cells
    assign w_link[0] = r_p2;

    for (genvar g = 0; g < tmm_pkg::CELLS; g++) begin : g_cell
        tmm_mac_cell #(
            .CELL_IDX(3'(g))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(r_clear),
            .i_link (w_link[g]),
            .o_link (w_link[g+1]),
            .o_acc  (w_acc[g])
        );
    end

    // output register, one beat per tile element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tmm_pkg::ST_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == tmm_pkg::ST_EMIT && w_out_free) begin
            r_out_row <= 4'(w_i);
            r_out_col <= 4'(w_j);
            r_out_prod <= w_acc[r_c];
            r_out_last <= (r_r == w_edge_m1) && (r_c == w_edge_m1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product_value = r_out_prod;
    assign o_last_of_tile = r_out_last;

    // checks on the sequencer and the chain
    a_issue_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tmm_pkg::ST_ISSUE |-> w_tx_ok && r_r <= w_edge_m1)
        else $error("issuing a term outside the tile grid");

    a_chain_empty_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tmm_pkg::ST_EMIT |-> !r_p1_valid && !r_p2.valid)
        else $error("reading sums while products are still in flight");

    a_tail_only_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[tmm_pkg::CELLS].valid |->
            (r_state == tmm_pkg::ST_ISSUE || r_state == tmm_pkg::ST_DRAIN))
        else $error("product left the chain after drain");

    a_dest_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2.valid |-> r_p2.dest <= w_edge_m1)
        else $error("product addressed beyond the tile edge");

endmodule

// ----- sv/tmm_mac_cell.sv -----
// one accumulating cell of the chain, holding the sum for one tile column
module tmm_mac_cell #(
    parameter logic [2:0] CELL_IDX = 3'd0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  tmm_pkg::t_link            i_link,
    output tmm_pkg::t_link            o_link,
    output logic [tmm_pkg::DATA_W-1:0] o_acc
);

    tmm_pkg::t_link r_link;
    logic [tmm_pkg::DATA_W-1:0] r_acc;

    // hand the product on to the neighbor every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
        end
        r_link.dest <= i_link.dest;
        r_link.prod <= i_link.prod;
    end

    // accumulate products addressed to this cell, wrapping at 32 bits
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (i_link.valid && i_link.dest == CELL_IDX) begin
            r_acc <= r_acc + i_link.prod;
        end
    end

    assign o_link = r_link;
    assign o_acc = r_acc;

endmodule

// ----- tb/sv/tiled_integer_matrix_multiply_tb.sv -----
// testbench for the tiled matrix multiply block: random loads and tile requests checked beat by beat
`timescale 1ns / 1ps

module tiled_integer_matrix_multiply_tb;

    localparam int DIM = 16;
    localparam logic [2:0] ADDR_TILE_LOG2 = 3'd0;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic [7:0]  tile;
    } t_request;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] product;
        logic        last;
    } t_element;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_req_type = '0;
    logic [3:0] i_row_index = '0, i_col_index = '0;
    logic signed [31:0] i_element_value = '0;
    logic [7:0] i_tile_index = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [3:0] o_out_row, o_out_col;
    logic signed [31:0] o_product_value;
    logic o_last_of_tile;

    tiled_integer_matrix_multiply #(.MATRIX_DIM(DIM)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the stores and the register
    logic [31:0] a_store [DIM*DIM];
    logic [31:0] b_store [DIM*DIM];
    logic [1:0] tile_log2 = tmm_pkg::TILE_LOG2_RESET;

    t_request pending_requests[$];
    t_element expected_elements[$];
    int mismatches = 0;

    // dot product of row r of A and column c of B, wrapping at 32 bits
    function automatic logic [31:0] dot_sum(int r, int c);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < DIM; k++)
            acc = acc + a_store[r*DIM+k] * b_store[k*DIM+c];
        return acc;
    endfunction

    // tile inside the loaded top-left quarter at tile size s, the far corner one if last
    function automatic logic [7:0] corner_tile(logic [1:0] s, bit last);
        int side, span, tx, ty;
        side = DIM >> s;
        span = (DIM / 2) >> s;
        tx = last ? span - 1 : int'($urandom_range(span - 1));
        ty = last ? span - 1 : int'($urandom_range(span - 1));
        return 8'(tx * side + ty);
    endfunction

    // apply one accepted request to the predictor
    task automatic predict_request(t_request rq);
        int edge_len, per_side, tx, ty;
        t_element e;
        case (rq.req)
            tmm_pkg::REQ_LOAD_A: a_store[rq.row*DIM+rq.col] = rq.value;
            tmm_pkg::REQ_LOAD_B: b_store[rq.row*DIM+rq.col] = rq.value;
            tmm_pkg::REQ_COMPUTE: begin
                edge_len = 1 << tile_log2;
                per_side = DIM >> tile_log2;
                if (per_side != 0 && rq.tile < per_side * per_side) begin
                    tx = rq.tile / per_side;
                    ty = rq.tile % per_side;
                    for (int i = tx*edge_len; i < (tx+1)*edge_len; i++)
                        for (int j = ty*edge_len; j < (ty+1)*edge_len; j++) begin
                            e.row = i[3:0];
                            e.col = j[3:0];
                            e.product = dot_sum(i, j);
                            e.last = (i == (tx+1)*edge_len-1) && (j == (ty+1)*edge_len-1);
                            expected_elements.push_back(e);
                        end
                end
            end
            default: ;
        endcase
    endtask

    // driver: one beat from the pending queue after a random gap per item
    int in_gap = 0;
    always @(posedge i_clk) begin : drive
        int gap;
        gap = in_gap;
        if (i_in_valid && !o_in_stall) begin
            predict_request(pending_requests.pop_front());
            gap = $urandom_range(10);
        end
        if (i_in_valid && o_in_stall) begin
            // hold the stalled beat
        end else if (gap > 0) begin
            in_gap <= gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && i_rst_n) begin
            in_gap <= 0;
            i_in_valid <= 1'b1;
            i_req_type <= pending_requests[0].req;
            i_row_index <= pending_requests[0].row;
            i_col_index <= pending_requests[0].col;
            i_element_value <= pending_requests[0].value;
            i_tile_index <= pending_requests[0].tile;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // monitor: compare each output beat with the oldest expected element
    int out_wait = 0;
    always @(posedge i_clk) begin : check
        t_element got, want;
        int stall_draw;
        if (o_out_valid && !i_out_stall) begin
            got = {o_out_row, o_out_col, o_product_value, o_last_of_tile};
            if (expected_elements.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected beat row %0d col %0d value %h last %b",
                             got.row, got.col, got.product, got.last);
            end else begin
                want = expected_elements.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected r%0d c%0d %h l%b, got r%0d c%0d %h l%b",
                                 want.row, want.col, want.product, want.last,
                                 got.row, got.col, got.product, got.last);
                end
            end
        end
        // random stall stretch drawn after every accepted beat
        if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            stall_draw = $urandom_range(10);
            i_out_stall <= (stall_draw > 0);
            out_wait <= (stall_draw > 0) ? stall_draw - 1 : 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic add_load(logic [1:0] kind, int r, int c, logic [31:0] v);
        t_request rq;
        rq = '{req: kind, row: r[3:0], col: c[3:0], value: v, tile: 8'($urandom)};
        pending_requests.push_back(rq);
    endtask

    task automatic add_compute(logic [7:0] t);
        pending_requests.push_back('{req: tmm_pkg::REQ_COMPUTE, row: 4'($urandom),
                                     col: 4'($urandom), value: $urandom, tile: t});
    endtask

    // wait until every queued beat is accepted and answered, then let the block settle
    task automatic drain_phase();
        int guard;
        guard = 0;
        while ((pending_requests.size() != 0 || expected_elements.size() != 0 || i_in_valid)
               && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2000) @(posedge i_clk);
    endtask

    // random loads anywhere, computes only on tiles of the loaded quarter or out of range
    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 60)
                add_load(pick[0] ? tmm_pkg::REQ_LOAD_B : tmm_pkg::REQ_LOAD_A,
                         $urandom_range(DIM-1), $urandom_range(DIM-1), $urandom);
            else if (pick < 80)
                add_compute(corner_tile(tile_log2, 1'b0));
            else if (pick < 90)
                add_compute(8'((DIM >> tile_log2) * (DIM >> tile_log2)));
            else
                pending_requests.push_back('{req: REQ_UNUSED, row: 4'($urandom),
                                             col: 4'($urandom), value: $urandom,
                                             tile: 8'($urandom)});
        end
    endtask

    initial begin
        for (int k = 0; k < DIM*DIM; k++) begin
            a_store[k] = '0; b_store[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rows 0 to 7 of A and columns 0 to 7 of B with extremes,
        // so every tile of the top-left quarter reads only written entries
        for (int r = 0; r < DIM/2; r++)
            for (int c = 0; c < DIM; c++)
                add_load(tmm_pkg::REQ_LOAD_A, r, c, (r == 0) ? 32'h8000_0000 :
                         (r == 1) ? 32'h7fff_ffff : (r == 2) ? 32'hffff_ffff : $urandom);
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM/2; c++)
                add_load(tmm_pkg::REQ_LOAD_B, r, c,
                         (c == DIM/2-1) ? 32'hffff_ffff : $urandom);
        // unused request type, then corner tiles and out-of-range tiles at reset size
        pending_requests.push_back('{req: REQ_UNUSED, row: 4'hf, col: 4'hf,
                                     value: '1, tile: 8'hff});
        add_compute(8'd0);
        add_compute(corner_tile(tmm_pkg::TILE_LOG2_RESET, 1'b1));
        add_compute(8'd16);
        add_compute(8'd255);
        drain_phase();

        // sweep every tile size, extremes included
        for (int s = 0; s < 4; s++) begin
            logic [1:0] sz;
            sz = (s == 0) ? 2'd0 : (s == 1) ? 2'd3 : (s == 2) ? 2'd1 : 2'd2;
            apb_write(ADDR_TILE_LOG2, {30'd0, sz});
            tile_log2 = sz;
            add_compute(8'd0);
            add_compute(corner_tile(sz, 1'b1));
            add_compute(8'((DIM >> sz) * (DIM >> sz)));
            random_phase(8);
            drain_phase();
        end

        if (mismatches == 0 && expected_elements.size() == 0 && pending_requests.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- tiled_integer_matrix_multiply.f -----
sv/tmm_pkg.sv
sv/tmm_mac_cell.sv
sv/tiled_integer_matrix_multiply.sv
tb/sv/tiled_integer_matrix_multiply_tb.sv
